// File: rtl/pdp_pkg.sv
`default_nettype none
package pdp_pkg;

   typedef enum logic [4:0] {
      S_IDLE, S_RD0, S_RD1, S_RD2, S_LSQ0, S_LSQ1, S_PD0, S_PD1, S_TX, S_TY, S_DOT,
      S_DEC, S_DIV, S_OFFX, S_OFFY, S_EX, S_EY, S_ESUM, S_LEN, S_TL, S_TLW, S_UPD,
      S_FIN, S_OUT
   } state_type;

   typedef enum logic {
      OP_DIV,
      OP_SQRT
   } isu_op_type;

   typedef struct packed {
      logic       start;
      isu_op_type op;
   } isu_ctl_type;

   typedef struct packed {
      logic        done;
      logic [33:0] result;
   } isu_sts_type;

   localparam logic [1:0]  CSR_PATH_VALID  = 2'd0;
   localparam logic [1:0]  CSR_POINT_COUNT = 2'd1;

   localparam logic        REQ_WRITE = 1'b0;

   localparam logic [67:0] PROG_EPS_SQ = 68'd43;
   localparam logic [67:0] DIST_EPS_SQ = 68'd4295;
   localparam logic [67:0] ROUND_HALF  = 68'h4000_0000;
   localparam logic [31:0] T_ONE       = 32'h8000_0000;
   localparam logic [31:0] SAT31       = 32'h7FFF_FFFF;
   localparam logic [5:0]  DIV_STEPS   = 6'd31;
   localparam logic [5:0]  SQRT_STEPS  = 6'd34;

endpackage
`default_nettype wire

// File: rtl/pdp_mul.sv
`default_nettype none
module pdp_mul import pdp_pkg::*; (
   input  wire logic        clock,
   input  wire logic [33:0] op_a,
   input  wire logic [33:0] op_b,
   output logic      [67:0] prod
);

   logic [67:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

// File: rtl/pdp_isu.sv
`default_nettype none
module pdp_isu import pdp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire isu_ctl_type ctl,
   input  wire logic [67:0] arg_a,
   input  wire logic [67:0] arg_b,
   output isu_sts_type      sts
);

   logic        busy_ff;
   logic        done_ff;
   isu_op_type  op_ff;
   logic [5:0]  cnt_ff;
   logic [69:0] rem_ff;
   logic [67:0] rad_ff;
   logic [67:0] den_ff;
   logic [33:0] res_ff;

   logic [69:0] trial_a;
   logic [69:0] trial_b;
   logic [70:0] diff;
   logic        ge;

   // Restoring division shifts one bit a step; the root takes two radicand bits a step.
   always_comb begin
      if (op_ff == OP_DIV) begin
         trial_a = {rem_ff[68:0], 1'b0};
         trial_b = {2'b00, den_ff};
      end else begin
         trial_a = {rem_ff[67:0], rad_ff[67:66]};
         trial_b = {34'd0, res_ff, 2'b01};
      end
      diff = {1'b0, trial_a} - {1'b0, trial_b};
      ge   = ~diff[70];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_DIV;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            op_ff   <= ctl.op;
            cnt_ff  <= (ctl.op == OP_DIV) ? DIV_STEPS - 6'd1 : SQRT_STEPS - 6'd1;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         rem_ff <= (ctl.op == OP_DIV) ? {2'b00, arg_a} : 70'd0;
         rad_ff <= arg_a;
         den_ff <= arg_b;
         res_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[69:0] : trial_a;
         res_ff <= {res_ff[32:0], ge};
         rad_ff <= {rad_ff[65:0], 2'b00};
      end
   end

   assign sts.done   = done_ff;
   assign sts.result = res_ff;

endmodule
`default_nettype wire

// File: rtl/polyline_distance_progress.sv
`default_nettype none
// Distance of a query point to a stored polyline and arc length to its projection.
// A query on an invalid path or one with fewer than two waypoints answers from the idle
// state with zero distance and the query y as progress; otherwise each segment is taken
// in turn (no division when the projection clamps, no projection when it is degenerate),
// then the final root, through the shared iterative unit that does one quotient bit or
// one root bit a cycle and the single registered multiplier.
// Coordinates are signed Q16.16; both results saturate at 2^31-1 raw.
module polyline_distance_progress import pdp_pkg::*; #(
   parameter int MAX_POINTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // entry_index, coord_x, coord_y
   input  wire logic [0:0]  req_tuser,   // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [63:0] rsp_tdata,   // lateral_distance, along_progress
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [4:0]  csr_wdata
);

   localparam int AW   = $clog2(MAX_POINTS);
   localparam int CntW = $clog2(MAX_POINTS + 1);
   localparam int AccW = 35 + $clog2(MAX_POINTS);

   state_type state_ff, state_in;

   logic            path_valid_ff;
   logic [4:0]      point_count_ff;
   logic            rsp_valid_ff;
   logic [30:0]     rsp_dist_ff;
   logic [31:0]     rsp_prog_ff;

   logic [31:0]     mem_x [MAX_POINTS];
   logic [31:0]     mem_y [MAX_POINTS];
   logic [31:0]     rd_x_ff, rd_y_ff;
   logic [AW-1:0]   rd_addr;

   logic [31:0]     qry_x_ff, qry_y_ff, x1_ff, y1_ff;
   logic signed [32:0] sdx_ff, sdy_ff, qx_ff, qy_ff;
   logic signed [34:0] ex_ff, ey_ff;
   logic signed [68:0] dot_ff;
   logic [67:0]     lsq_ff, pd0_ff, pn_ff, best_d_ff, best_p_ff;
   logic [31:0]     t_ff;
   logic [33:0]     len_ff, term_ff;
   logic [AccW-1:0] acc_ff, prog_ff;
   logic [CntW-1:0] seg_ff;
   logic            have_d_ff, have_p_ff;

   logic [33:0]     mul_a, mul_b;
   logic [67:0]     prod;
   isu_ctl_type     isu_ctl;
   isu_sts_type     isu_sts;
   logic [67:0]     isu_arg_a;

   logic [CntW-1:0] n_eff;
   logic            req_acc, wr_en, short_path, last_seg, proj, dot_nonpos, dot_ge;
   logic            rsp_free, take_d;
   logic [67:0]     dd, best_d_nxt;
   logic [68:0]     prod69;
   logic [33:0]     off;
   logic signed [34:0] off35;

   function automatic logic [33:0] mag33(input logic signed [32:0] v);
      logic [33:0] e;
      e = {v[32], v};
      mag33 = v[32] ? (~e + 34'd1) : e;
   endfunction

   function automatic logic [33:0] mag35(input logic signed [34:0] v);
      logic [34:0] e;
      e = v[34] ? (~v + 35'd1) : v;
      mag35 = e[33:0];
   endfunction

   assign n_eff = (32'(point_count_ff) > MAX_POINTS) ? CntW'(MAX_POINTS)
                                                     : CntW'(point_count_ff);
   assign short_path = !path_valid_ff || (32'(n_eff) < 2);
   assign last_seg   = (32'(seg_ff) + 2) >= 32'(n_eff);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;
   assign wr_en      = req_acc && (req_tuser[0] == REQ_WRITE)
                       && (32'(req_tdata[3:0]) < MAX_POINTS);
   assign proj       = !(lsq_ff < PROG_EPS_SQ);
   assign dot_nonpos = dot_ff[68] || (dot_ff == 69'sd0);
   assign dot_ge     = !(dot_ff[67:0] < lsq_ff);
   assign prod69     = {1'b0, prod};
   assign off        = 34'((prod + ROUND_HALF) >> 31);
   assign off35      = {1'b0, off};
   assign dd         = (proj && !(lsq_ff < DIST_EPS_SQ)) ? pn_ff : pd0_ff;
   assign take_d     = !have_d_ff || (dd < best_d_ff);
   assign best_d_nxt = take_d ? dd : best_d_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         path_valid_ff  <= 1'b0;
         point_count_ff <= 5'd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PATH_VALID:  path_valid_ff  <= csr_wdata[0];
            CSR_POINT_COUNT: point_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[AW'(req_tdata[3:0])] <= req_tdata[35:4];
         mem_y[AW'(req_tdata[3:0])] <= req_tdata[67:36];
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
   end

   pdp_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   pdp_isu u_isu (
      .clock (clock),
      .reset (reset),
      .ctl   (isu_ctl),
      .arg_a (isu_arg_a),
      .arg_b (lsq_ff),
      .sts   (isu_sts)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_acc && req_tuser[0] != REQ_WRITE && !short_path) state_in = S_RD0;
         S_RD0:  state_in = S_RD1;
         S_RD1:  state_in = S_RD2;
         S_RD2:  state_in = S_LSQ0;
         S_LSQ0: state_in = S_LSQ1;
         S_LSQ1: state_in = S_PD0;
         S_PD0:  state_in = S_PD1;
         S_PD1:  state_in = S_TX;
         S_TX:   state_in = S_TY;
         S_TY:   state_in = S_DOT;
         S_DOT:  state_in = S_DEC;
         S_DEC: begin
            if (!proj) state_in = S_UPD;
            else if (dot_nonpos || dot_ge) state_in = S_OFFX;
            else state_in = S_DIV;
         end
         S_DIV:  if (isu_sts.done) state_in = S_OFFX;
         S_OFFX: state_in = S_OFFY;
         S_OFFY: state_in = S_EX;
         S_EX:   state_in = S_EY;
         S_EY:   state_in = S_ESUM;
         S_ESUM: state_in = S_LEN;
         S_LEN:  if (isu_sts.done) state_in = S_TL;
         S_TL:   state_in = S_TLW;
         S_TLW:  state_in = S_UPD;
         S_UPD:  state_in = last_seg ? S_FIN : S_RD0;
         S_FIN:  if (isu_sts.done) state_in = S_OUT;
         S_OUT:  if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = (state_ff == S_IDLE) && rsp_free;
      rd_addr       = (state_ff == S_RD0) ? AW'(seg_ff) : AW'(seg_ff + 1'b1);
      mul_a         = '0;
      mul_b         = '0;
      isu_ctl.start = 1'b0;
      isu_ctl.op    = OP_DIV;
      isu_arg_a     = dot_ff[67:0];
      case (state_ff)
         S_LSQ0: begin mul_a = mag33(sdx_ff); mul_b = mag33(sdx_ff); end
         S_LSQ1: begin mul_a = mag33(sdy_ff); mul_b = mag33(sdy_ff); end
         S_PD0:  begin mul_a = mag33(qx_ff);  mul_b = mag33(qx_ff);  end
         S_PD1:  begin mul_a = mag33(qy_ff);  mul_b = mag33(qy_ff);  end
         S_TX:   begin mul_a = mag33(qx_ff);  mul_b = mag33(sdx_ff); end
         S_TY:   begin mul_a = mag33(qy_ff);  mul_b = mag33(sdy_ff); end
         S_OFFX: begin mul_a = {2'b00, t_ff}; mul_b = mag33(sdx_ff); end
         S_OFFY: begin mul_a = {2'b00, t_ff}; mul_b = mag33(sdy_ff); end
         S_EX:   begin mul_a = mag35(ex_ff);  mul_b = mag35(ex_ff);  end
         S_EY:   begin mul_a = mag35(ey_ff);  mul_b = mag35(ey_ff);  end
         S_TL:   begin mul_a = {2'b00, t_ff}; mul_b = len_ff;        end
         S_DEC: begin
            isu_ctl.start = proj && !dot_nonpos && !dot_ge;
         end
         S_ESUM: begin
            isu_ctl.start = 1'b1;
            isu_ctl.op    = OP_SQRT;
            isu_arg_a     = lsq_ff;
         end
         S_UPD: begin
            isu_ctl.start = last_seg;
            isu_ctl.op    = OP_SQRT;
            isu_arg_a     = best_d_nxt;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == S_IDLE && req_acc && req_tuser[0] != REQ_WRITE && short_path)
             || (state_ff == S_OUT && rsp_free)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            qry_x_ff  <= req_tdata[35:4];
            qry_y_ff  <= req_tdata[67:36];
            seg_ff    <= '0;
            acc_ff    <= '0;
            prog_ff   <= '0;
            have_d_ff <= 1'b0;
            have_p_ff <= 1'b0;
            if (req_acc && req_tuser[0] != REQ_WRITE && short_path) begin
               rsp_dist_ff <= '0;
               rsp_prog_ff <= req_tdata[67:36];
            end
         end
         S_RD1: begin
            x1_ff <= rd_x_ff;
            y1_ff <= rd_y_ff;
         end
         S_RD2: begin
            sdx_ff <= {rd_x_ff[31], rd_x_ff} - {x1_ff[31], x1_ff};
            sdy_ff <= {rd_y_ff[31], rd_y_ff} - {y1_ff[31], y1_ff};
            qx_ff  <= {qry_x_ff[31], qry_x_ff} - {x1_ff[31], x1_ff};
            qy_ff  <= {qry_y_ff[31], qry_y_ff} - {y1_ff[31], y1_ff};
         end
         S_LSQ1: lsq_ff <= prod;
         S_PD0:  lsq_ff <= lsq_ff + prod;
         S_PD1:  pd0_ff <= prod;
         S_TX:   pd0_ff <= pd0_ff + prod;
         S_TY:   dot_ff <= (qx_ff[32] ^ sdx_ff[32]) ? -$signed(prod69) : $signed(prod69);
         S_DOT:  dot_ff <= (qy_ff[32] ^ sdy_ff[32]) ? dot_ff - $signed(prod69)
                                                    : dot_ff + $signed(prod69);
         S_DEC: begin
            if (dot_nonpos) t_ff <= '0;
            else if (dot_ge) t_ff <= T_ONE;
         end
         S_DIV: if (isu_sts.done) t_ff <= {1'b0, isu_sts.result[30:0]};
         S_OFFY: begin
            ex_ff <= sdx_ff[32] ? {{2{qx_ff[32]}}, qx_ff} + off35
                                : {{2{qx_ff[32]}}, qx_ff} - off35;
         end
         S_EX: begin
            ey_ff <= sdy_ff[32] ? {{2{qy_ff[32]}}, qy_ff} + off35
                                : {{2{qy_ff[32]}}, qy_ff} - off35;
         end
         S_EY:   pn_ff <= prod;
         S_ESUM: pn_ff <= pn_ff + prod;
         S_LEN:  if (isu_sts.done) len_ff <= isu_sts.result;
         S_TLW:  term_ff <= off;
         S_UPD: begin
            best_d_ff <= best_d_nxt;
            have_d_ff <= 1'b1;
            if (proj) begin
               if (!have_p_ff || (pn_ff < best_p_ff)) begin
                  best_p_ff <= pn_ff;
                  have_p_ff <= 1'b1;
                  prog_ff   <= acc_ff + AccW'(term_ff);
               end
               acc_ff <= acc_ff + AccW'(len_ff);
            end
            seg_ff <= seg_ff + 1'b1;
         end
         S_FIN: begin
            if (isu_sts.done) begin
               rsp_dist_ff <= (isu_sts.result > 34'(SAT31)) ? SAT31[30:0]
                                                           : isu_sts.result[30:0];
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_prog_ff <= (prog_ff > AccW'(SAT31)) ? SAT31 : prog_ff[31:0];
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_prog_ff, rsp_dist_ff};

`ifndef SYNTHESIS
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      isu_sts.done |-> (state_ff == S_DIV || state_ff == S_LEN || state_ff == S_FIN))
      else $error("iterative unit finished outside a waiting state");
   a_seg_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD0) |-> ((32'(seg_ff) + 1) < 32'(n_eff)))
      else $error("segment index beyond the path");
   a_best_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD) |=> have_d_ff)
      else $error("no distance candidate after a segment update");
`endif

endmodule
`default_nettype wire

// File: test/polyline_distance_progress_tb.sv
`timescale 1ns / 1ps

module polyline_distance_progress_tb;
   import pdp_pkg::*;

   localparam logic       REQ_QUERY      = 1'b1;
   localparam logic [1:0] CSR_SPARE_2    = 2'd2;
   localparam logic [1:0] CSR_SPARE_3    = 2'd3;
   localparam int         SLOTS          = 16;
   localparam int         CYCLE_LIMIT    = 4000000;
   localparam int         SETTLE_CYCLES  = 100;
   localparam int         LONG_HOLD      = 3000;
   localparam int         RANDOM_PHASES  = 12;
   localparam int         PHASE_ITEMS    = 36;

   typedef struct {
      logic [30:0] lateral;
      logic [31:0] progress;
   } path_answer_type;

   class path_scoreboard;
      int              wp_x [SLOTS];
      int              wp_y [SLOTS];
      logic            valid_reg;
      logic [4:0]      count_reg;
      path_answer_type answers [$];
      int              errors;
      int              checked;

      function new();
         valid_reg = 1'b0;
         count_reg = 5'd0;
         errors = 0;
         checked = 0;
         for (int i = 0; i < SLOTS; i++) begin
            wp_x[i] = 0;
            wp_y[i] = 0;
         end
      endfunction

      function automatic logic [63:0] mag(longint a);
         return (a < 0) ? 64'(-a) : 64'(a);
      endfunction

      function automatic logic [127:0] square(longint a);
         logic [127:0] u;
         u = {64'd0, mag(a)};
         return u * u;
      endfunction

      function automatic logic [63:0] root(logic [127:0] v);
         logic [63:0] r;
         logic [63:0] c;
         r = 64'd0;
         for (int b = 33; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (v >= {64'd0, c} * {64'd0, c}) r = c;
         end
         return r;
      endfunction

      function automatic longint offset(longint d, logic [63:0] t);
         logic [63:0] off;
         off = (t * mag(d) + 64'h4000_0000) >> 31;
         return (d < 0) ? -longint'(off) : longint'(off);
      endfunction

      function void write_csr(logic [1:0] index, logic [4:0] value);
         if (index == CSR_PATH_VALID) valid_reg = value[0];
         else if (index == CSR_POINT_COUNT) count_reg = value;
      endfunction

      function void note_input(logic kind, logic [3:0] slot, int x, int y);
         path_answer_type ans;
         int unsigned  n;
         longint       px, py, x1, y1, sdx, sdy, qx, qy;
         logic [127:0] lsq, pd, dd, best_d, best_p, pos, neg, rem;
         logic [63:0]  t, len, acc, prog, lat_dist;
         bit           have_d, have_p;
         if (kind == REQ_WRITE) begin
            wp_x[slot] = x;
            wp_y[slot] = y;
            return;
         end
         px = x;
         py = y;
         n = (count_reg > SLOTS) ? SLOTS : count_reg;
         if (!valid_reg || n < 2) begin
            ans.lateral = '0;
            ans.progress = y;
            answers.push_back(ans);
            return;
         end
         have_d = 0;
         have_p = 0;
         best_d = '0;
         best_p = '0;
         acc = '0;
         prog = '0;
         for (int i = 0; i + 1 < n; i++) begin
            x1 = wp_x[i];
            y1 = wp_y[i];
            sdx = longint'(wp_x[i + 1]) - x1;
            sdy = longint'(wp_y[i + 1]) - y1;
            qx = px - x1;
            qy = py - y1;
            lsq = square(sdx) + square(sdy);
            pd = square(qx) + square(qy);
            dd = pd;
            t = '0;
            if (lsq >= PROG_EPS_SQ) begin
               pos = '0;
               neg = '0;
               if ((qx < 0) != (sdx < 0)) neg += {64'd0, mag(qx)} * {64'd0, mag(sdx)};
               else pos += {64'd0, mag(qx)} * {64'd0, mag(sdx)};
               if ((qy < 0) != (sdy < 0)) neg += {64'd0, mag(qy)} * {64'd0, mag(sdy)};
               else pos += {64'd0, mag(qy)} * {64'd0, mag(sdy)};
               if (neg < pos) begin
                  rem = pos - neg;
                  if (rem >= lsq) begin
                     t = {32'd0, T_ONE};
                  end else begin
                     for (int k = 0; k < 31; k++) begin
                        rem = rem << 1;
                        t = t << 1;
                        if (rem >= lsq) begin
                           rem = rem - lsq;
                           t[0] = 1'b1;
                        end
                     end
                  end
               end
               pd = square(qx - offset(sdx, t)) + square(qy - offset(sdy, t));
               if (lsq >= DIST_EPS_SQ) dd = pd;
            end
            if (!have_d || dd < best_d) begin
               best_d = dd;
               have_d = 1;
            end
            if (lsq >= PROG_EPS_SQ) begin
               len = root(lsq);
               if (!have_p || pd < best_p) begin
                  best_p = pd;
                  have_p = 1;
                  prog = acc + ((t * len + 64'h4000_0000) >> 31);
               end
               acc += len;
            end
         end
         lat_dist = root(best_d);
         ans.lateral = (lat_dist > {32'd0, SAT31}) ? SAT31[30:0] : lat_dist[30:0];
         ans.progress = (prog > {32'd0, SAT31}) ? SAT31 : prog[31:0];
         answers.push_back(ans);
      endfunction

      function void check_result(logic [63:0] data);
         path_answer_type ans;
         checked++;
         if (answers.size() == 0) begin
            $error("unexpected result transaction %h", data);
            errors++;
            return;
         end
         ans = answers.pop_front();
         if (data[30:0] !== ans.lateral) begin
            $error("lateral_distance expected %0d actual %0d", ans.lateral, data[30:0]);
            errors++;
         end
         if (data[62:31] !== ans.progress) begin
            $error("along_progress expected %0d actual %0d",
                   $signed(ans.progress), $signed(data[62:31]));
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [4:0]  csr_wdata = '0;

   path_scoreboard sb = new();
   int  cycles = 0;
   int  sent = 0;
   int  csr_writes = 0;
   bit  send_idle_en = 1'b1;
   bit  recv_idle_en = 1'b1;
   bit  long_hold_req = 1'b0;
   int  last_x = 0;
   int  last_y = 0;

   polyline_distance_progress dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : receiver
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (long_hold_req) begin
            hold = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (recv_idle_en && $urandom_range(0, 9) == 0) begin
            hold = $urandom_range(1, 13) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_item(logic kind, logic [3:0] slot, int x, int y);
      if (send_idle_en && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {4'd0, y, x, slot};
      do @(posedge clock); while (!req_tready);
      sb.note_input(kind, slot, x, y);
      sent++;
      if (kind == REQ_WRITE) begin
         last_x = x;
         last_y = y;
      end
   endtask

   task automatic write_reg(logic [1:0] index, logic [4:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_csr(index, value);
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_path(logic valid, logic [4:0] count);
      drain();
      write_reg(CSR_PATH_VALID, {4'd0, valid});
      write_reg(CSR_POINT_COUNT, count);
   endtask

   function automatic int near(int base, int span);
      return base + $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic int pick_coord(int base);
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom;
         3, 4, 5: return near(base, 1 << 20);
         6:       return near(base, 3);
         7:       return near(base, 40);
         8:       return near(base, 1 << 26);
         default: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   initial begin : stimulus
      int unsigned sel;
      int          s, qx, qy;
      logic [4:0]  cnt;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty, invalid path: answers fall back to the query y.
      set_path(1'b0, 5'd0);
      send_item(REQ_QUERY, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(REQ_QUERY, 4'd15, 32'h7FFF_FFFF, 32'h8000_0000);

      send_item(REQ_WRITE, 4'd0, 0, 0);
      send_item(REQ_WRITE, 4'd1, 10 << 16, 0);
      send_item(REQ_WRITE, 4'd2, 10 << 16, 5 << 16);
      send_item(REQ_WRITE, 4'd3, -(3 << 16), 7 << 16);
      send_item(REQ_WRITE, 4'd4, -(3 << 16) + 1, (7 << 16) + 1);
      send_item(REQ_WRITE, 4'd5, -(3 << 16) + 21, (7 << 16) + 31);
      send_item(REQ_WRITE, 4'd6, 32'h8000_0000, 32'h8000_0000);
      send_item(REQ_WRITE, 4'd7, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      for (int i = 8; i < SLOTS; i++) send_item(REQ_WRITE, 4'(i), $urandom, $urandom);

      set_path(1'b1, 5'd2);
      send_item(REQ_QUERY, 4'd0, -(5 << 16), 3 << 16);
      send_item(REQ_QUERY, 4'd0, 5 << 16, 3 << 16);
      send_item(REQ_QUERY, 4'd0, 15 << 16, -(3 << 16));
      send_item(REQ_QUERY, 4'd0, 5 << 16, 0);
      set_path(1'b1, 5'd6);
      send_item(REQ_QUERY, 4'd0, -(3 << 16) + 5, (7 << 16) + 9);
      set_path(1'b1, 5'd8);
      send_item(REQ_QUERY, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(REQ_QUERY, 4'd0, 32'h7FFF_FFFF, 32'h8000_0000);
      set_path(1'b1, 5'd31);
      write_reg(CSR_SPARE_2, 5'd0);
      write_reg(CSR_SPARE_3, 5'd31);
      send_item(REQ_QUERY, 4'd0, $urandom, $urandom);
      set_path(1'b0, 5'd16);
      send_item(REQ_QUERY, 4'd0, 1 << 16, -(1 << 16));

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         sel = $urandom_range(0, 9);
         case (sel)
            0:       cnt = 5'd0;
            1:       cnt = 5'd1;
            2:       cnt = 5'd2;
            7:       cnt = 5'd16;
            8:       cnt = 5'($urandom_range(17, 31));
            9:       cnt = 5'($urandom_range(7, 15));
            default: cnt = 5'($urandom_range(2, 6));
         endcase
         if (ph == RANDOM_PHASES - 1) begin
            send_idle_en = 1'b0;
            recv_idle_en = 1'b0;
         end
         set_path($urandom_range(0, 4) != 0, cnt);
         if (ph == 2) long_hold_req = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 99) < 35) begin
               send_item(REQ_WRITE, 4'($urandom), pick_coord(last_x), pick_coord(last_y));
            end else begin
               s = $urandom_range(0, SLOTS - 1);
               if ($urandom_range(0, 1) != 0) begin
                  qx = near(sb.wp_x[s], 1 << 20);
                  qy = near(sb.wp_y[s], 1 << 20);
               end else begin
                  qx = pick_coord(sb.wp_x[s]);
                  qy = pick_coord(sb.wp_y[s]);
               end
               send_item(REQ_QUERY, 4'($urandom), qx, qy);
            end
         end
      end

      drain();
      if (sb.answers.size() != 0) begin
         $error("%0d expected results never arrived", sb.answers.size());
         sb.errors++;
      end
      $display("Run: %0d input transactions, %0d results checked, %0d register writes,",
               sent, sb.checked, csr_writes);
      $display("     %0d random phases over %0d cycles.", RANDOM_PHASES, cycles);
      if (sb.errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
